// File: hdl/wsfd_pkg.sv
// Package for the WebSocket frame deframer: parse phase codes and header constants.
// No dependencies; used by websocket_frame_deframer_core.
`timescale 1ns / 1ps

package wsfd_pkg;

	typedef enum logic [2:0] {
		PH_HDR0 = 3'd0,
		PH_HDR1 = 3'd1,
		PH_EXT  = 3'd2,
		PH_KEY  = 3'd3,
		PH_PAY  = 3'd4
	} phase_t;

	localparam logic [3:0] OPC_TEXT   = 4'h1;
	localparam logic [6:0] LEN_EXT16  = 7'd126;
	localparam logic [6:0] LEN_EXT64  = 7'd127;
	localparam logic [2:0] EXT16_LAST = 3'd1;
	localparam logic [2:0] EXT64_LAST = 3'd7;
	localparam logic [1:0] KEY_LAST   = 2'd3;

endpackage

// File: hdl/websocket_frame_deframer_core.sv
// Top level of the WebSocket frame deframer: header parser, unmasking and output buffer.
// Depends on wsfd_pkg for phase codes and header constants.
`timescale 1ns / 1ps

// Takes a received byte stream, one byte per transaction, holding back-to-back
// WebSocket frames (opcode byte, mask flag and 7-bit length, optional 16- or
// 64-bit big-endian extended length, optional 4-byte masking key, payload).
// Payload bytes of text frames (opcode 1) come out unmasked, one per
// transaction, with last_of_frame set on the final byte of each frame; other
// opcodes and zero-length frames produce nothing. FIN and RSV are ignored and
// the full 64-bit length is honored. Every byte is parsed in the cycle it is
// accepted: the parse state updates at the accepting edge and any result lands
// in the output register on the same edge (or in the skid register when a
// stalled result still holds the output register), so one byte per cycle is
// sustained while in_stall is low; with the output free, a byte's result is
// visible the cycle after it is taken. A two-entry output buffer (output
// register plus skid register) lets the block keep taking bytes while a result waits;
// in_stall rises only once both entries are full, that is when the consumer stalls
// a waiting result and another one arrives, and it comes straight from a flop.
module websocket_frame_deframer_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] payload_byte,
	output logic       last_of_frame
);

	// Parse state
	wsfd_pkg::phase_t phase_q, phase_d;
	logic [2:0]  ext_cnt_q, ext_cnt_d;
	logic [63:0] rem_len_q, rem_len_d;
	logic [31:0] key_q, key_d;
	logic [1:0]  key_pos_q, key_pos_d;
	logic        masked_q, masked_d;
	logic        keep_q, keep_d;

	// Output buffer: head is what the port shows, skid catches one more result
	logic       out_valid_q, skid_valid_q;
	logic [7:0] out_byte_q, skid_byte_q;
	logic       out_last_q, skid_last_q;

	logic        in_acc, emit, pop;
	logic [7:0]  res_byte;
	logic        res_last;
	logic [63:0] ext_len;
	logic [6:0]  len7;
	logic [7:0]  key_byte;

	assign in_acc = in_valid & ~in_stall;
	assign pop    = out_valid_q & ~out_stall;
	assign len7   = rx_byte[6:0];
	assign ext_len = {rem_len_q[55:0], rx_byte};

	always_comb begin
		unique case (key_pos_q)
			2'd0:    key_byte = key_q[7:0];
			2'd1:    key_byte = key_q[15:8];
			2'd2:    key_byte = key_q[23:16];
			default: key_byte = key_q[31:24];
		endcase
	end

	// Next parse state for the byte on rx_byte; applied only on acceptance.
	always_comb begin
		phase_d   = phase_q;
		ext_cnt_d = ext_cnt_q;
		rem_len_d = rem_len_q;
		key_d     = key_q;
		key_pos_d = key_pos_q;
		masked_d  = masked_q;
		keep_d    = keep_q;
		emit      = 1'b0;
		res_byte  = rx_byte ^ key_byte;
		res_last  = (rem_len_q == 64'd1);

		unique case (phase_q)
			wsfd_pkg::PH_HDR1: begin
				masked_d = rx_byte[7];
				if (len7 == wsfd_pkg::LEN_EXT16) begin
					rem_len_d = '0;
					ext_cnt_d = wsfd_pkg::EXT16_LAST;
					phase_d   = wsfd_pkg::PH_EXT;
				end else if (len7 == wsfd_pkg::LEN_EXT64) begin
					rem_len_d = '0;
					ext_cnt_d = wsfd_pkg::EXT64_LAST;
					phase_d   = wsfd_pkg::PH_EXT;
				end else begin
					rem_len_d = {57'd0, len7};
					key_pos_d = '0;
					key_d     = '0;
					if (rx_byte[7])
						phase_d = wsfd_pkg::PH_KEY;
					else if (len7 == 7'd0)
						phase_d = wsfd_pkg::PH_HDR0;
					else
						phase_d = wsfd_pkg::PH_PAY;
				end
			end
			wsfd_pkg::PH_EXT: begin
				rem_len_d = ext_len;
				if (ext_cnt_q == 3'd0) begin
					key_pos_d = '0;
					key_d     = '0;
					if (masked_q)
						phase_d = wsfd_pkg::PH_KEY;
					else if (ext_len == 64'd0)
						phase_d = wsfd_pkg::PH_HDR0;
					else
						phase_d = wsfd_pkg::PH_PAY;
				end else begin
					ext_cnt_d = ext_cnt_q - 3'd1;
				end
			end
			wsfd_pkg::PH_KEY: begin
				// key was cleared before the first key byte, so a plain write matches OR-in
				unique case (key_pos_q)
					2'd0:    key_d[7:0]   = rx_byte;
					2'd1:    key_d[15:8]  = rx_byte;
					2'd2:    key_d[23:16] = rx_byte;
					default: key_d[31:24] = rx_byte;
				endcase
				key_pos_d = key_pos_q + 2'd1;
				if (key_pos_q == wsfd_pkg::KEY_LAST)
					phase_d = (rem_len_q == 64'd0) ? wsfd_pkg::PH_HDR0 : wsfd_pkg::PH_PAY;
			end
			wsfd_pkg::PH_PAY: begin
				key_pos_d = key_pos_q + 2'd1;
				rem_len_d = rem_len_q - 64'd1;
				if (res_last)
					phase_d = wsfd_pkg::PH_HDR0;
				emit = keep_q;
			end
			default: begin
				// first header byte; unused codes fall here as well
				keep_d  = (rx_byte[3:0] == wsfd_pkg::OPC_TEXT);
				phase_d = wsfd_pkg::PH_HDR1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= wsfd_pkg::PH_HDR0;
			ext_cnt_q <= '0;
			rem_len_q <= '0;
			key_q     <= '0;
			key_pos_q <= '0;
			masked_q  <= 1'b0;
			keep_q    <= 1'b0;
		end else if (in_acc) begin
			phase_q   <= phase_d;
			ext_cnt_q <= ext_cnt_d;
			rem_len_q <= rem_len_d;
			key_q     <= key_d;
			key_pos_q <= key_pos_d;
			masked_q  <= masked_d;
			keep_q    <= keep_d;
		end
	end

	// Output buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q) begin
				out_valid_q <= in_acc & emit;
			end else if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= in_acc & emit;
				end else begin
					out_valid_q <= in_acc & emit;
				end
			end else if (in_acc && emit) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// Output buffer data
	always_ff @(posedge clk) begin
		if (!out_valid_q || (pop && !skid_valid_q)) begin
			out_byte_q <= res_byte;
			out_last_q <= res_last;
		end else if (pop) begin
			out_byte_q <= skid_byte_q;
			out_last_q <= skid_last_q;
		end
		if (in_acc && emit && out_valid_q && (!pop || skid_valid_q)) begin
			skid_byte_q <= res_byte;
			skid_last_q <= res_last;
		end
	end

	assign in_stall      = skid_valid_q;
	assign out_valid     = out_valid_q;
	assign payload_byte  = out_byte_q;
	assign last_of_frame = out_last_q;

endmodule

// File: hdl/wsfd_checker.sv
// Port-level checker for websocket_frame_deframer_core, with its bind statement.
// Depends on the top level's ports only.
`timescale 1ns / 1ps

module wsfd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] rx_byte,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] payload_byte,
	input logic       last_of_frame
);

	// reset empties the buffer and opens the input
	a_reset_clear: assert property (@(posedge clk)
		!arst_n |=> !out_valid && !in_stall)
		else $error("buffer not empty after reset");

	// a held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(payload_byte)
			&& $stable(last_of_frame))
		else $error("stalled result changed");

	// a stalled input transaction stays put
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(rx_byte))
		else $error("stalled input changed");

	// input stalls only with a result waiting
	a_stall_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output");

	// the buffer fills only behind a stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall && in_valid))
		else $error("input stall without output backpressure");

endmodule

bind websocket_frame_deframer_core wsfd_checker u_wsfd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.rx_byte       (rx_byte),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.payload_byte  (payload_byte),
	.last_of_frame (last_of_frame)
);
